[hdl/lste_pkg.sv]
package lste_pkg;

	localparam int CHANNELS = 15;
	localparam int CH_BITS  = 4;
	localparam int CNT_BITS = 4;
	localparam int ERR_BITS = 6;
	localparam int CFG_BITS = 4;

	typedef logic [CH_BITS-1:0]         chan_t;
	typedef logic [CNT_BITS-1:0]        cnt_t;
	typedef logic [CHANNELS-1:0]        pattern_t;
	typedef logic signed [ERR_BITS-1:0] err_t;
	typedef logic [CFG_BITS-1:0]        cfg_data_t;

	typedef enum logic {
		REG_NORMAL_WIDTH = 1'b0,
		REG_EDGE_COUNT   = 1'b1
	} cfg_idx_t;

	typedef enum logic {
		KIND_SAMPLE = 1'b0,
		KIND_LOAD   = 1'b1
	} kind_t;

	localparam chan_t     EDGE_TOP         = chan_t'(CHANNELS - 1);
	localparam chan_t     CHAN_ZERO        = '0;
	localparam cnt_t      TRACK_MIN        = cnt_t'(2);
	localparam cfg_data_t NORMAL_WIDTH_RST = cfg_data_t'(7);
	localparam cfg_data_t EDGE_COUNT_RST   = cfg_data_t'(10);

	// pattern snapshot handed from the hysteresis stage to the track stage
	typedef struct packed {
		logic     valid;
		pattern_t pattern;
	} snap_t;

	function automatic err_t dir_entry(input chan_t idx);
		err_t d;
		unique case (idx)
			4'd0:    d = -err_t'(30);
			4'd1:    d = -err_t'(20);
			4'd2:    d = -err_t'(16);
			4'd3:    d = -err_t'(12);
			4'd4:    d = -err_t'(10);
			4'd5:    d = -err_t'(7);
			4'd6:    d = -err_t'(3);
			4'd7:    d = err_t'(0);
			4'd8:    d = err_t'(3);
			4'd9:    d = err_t'(7);
			4'd10:   d = err_t'(10);
			4'd11:   d = err_t'(12);
			4'd12:   d = err_t'(16);
			4'd13:   d = err_t'(20);
			default: d = err_t'(30);
		endcase
		return d;
	endfunction

endpackage

[hdl/lste_if.sv]
interface lste_in_if #(
	parameter int SAMPLE_BITS = 12
);
	logic                           valid;
	logic                           ready;
	logic                           kind;
	logic [lste_pkg::CH_BITS-1:0]   channel;
	logic [SAMPLE_BITS-1:0]         sample;
	logic [SAMPLE_BITS-1:0]         high_threshold;
	logic [SAMPLE_BITS-1:0]         low_threshold;
	logic                           last;

	modport source (
		output valid, kind, channel, sample, high_threshold, low_threshold, last,
		input  ready
	);
	modport sink (
		input  valid, kind, channel, sample, high_threshold, low_threshold, last,
		output ready
	);
endinterface

interface lste_out_if;
	logic                                  valid;
	logic                                  ready;
	logic [lste_pkg::CHANNELS-1:0]         pattern;
	logic [lste_pkg::CNT_BITS-1:0]         track_count;
	logic [lste_pkg::CH_BITS-1:0]          left_point;
	logic [lste_pkg::CH_BITS-1:0]          right_point;
	logic                                  held;
	logic                                  edge_res;
	logic signed [lste_pkg::ERR_BITS-1:0]  steer_error;

	modport source (
		output valid, pattern, track_count, left_point, right_point, held, edge_res,
			steer_error,
		input  ready
	);
	modport sink (
		input  valid, pattern, track_count, left_point, right_point, held, edge_res,
			steer_error,
		output ready
	);
endinterface

[hdl/line_sensor_track_error.sv]
// a result word is formed from its last sample word through the input, snapshot and result registers
// throughput: one input word per cycle; input, snapshot and result registers advance together
// and hold while the result register is full and not taken
// reset: arst_n clears channel bits, kept and scan track, prior error and valid flags,
// and loads the width and edge limits with 7 and 10; thresholds are undefined until loaded
module line_sensor_track_error #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  lste_pkg::cfg_idx_t   cfg_index,
	input  lste_pkg::cfg_data_t  cfg_data,
	lste_in_if.sink              items,
	lste_out_if.source           results
);
	import lste_pkg::*;

	snap_t snap;
	logic  advance;

	lste_hyst #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_hyst (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.items   (items),
		.snap    (snap)
	);

	lste_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.snap      (snap),
		.advance   (advance),
		.results   (results)
	);

endmodule

[hdl/lste_hyst.sv]
module lste_hyst #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	lste_in_if.sink           items,
	output lste_pkg::snap_t   snap
);
	import lste_pkg::*;

	logic                   valid_s1;
	logic                   kind_s1;
	chan_t                  channel_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic [SAMPLE_BITS-1:0] high_s1;
	logic [SAMPLE_BITS-1:0] low_s1;
	logic                   last_s1;

	logic [SAMPLE_BITS-1:0] thr_high_q [CHANNELS];
	logic [SAMPLE_BITS-1:0] thr_low_q  [CHANNELS];
	pattern_t               bits_q;
	pattern_t               bits_next;
	logic                   in_range;
	logic                   is_load;
	logic                   is_sample;
	logic                   set_bit;
	logic                   clr_bit;
	logic                   snap_valid_s2;
	pattern_t               snap_pattern_s2;

	assign items.ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && items.valid) begin
			kind_s1    <= items.kind;
			channel_s1 <= items.channel;
			sample_s1  <= items.sample;
			high_s1    <= items.high_threshold;
			low_s1     <= items.low_threshold;
			last_s1    <= items.last;
		end
	end

	assign in_range  = channel_s1 < chan_t'(CHANNELS);
	assign is_load   = valid_s1 && (kind_s1 == KIND_LOAD);
	assign is_sample = valid_s1 && (kind_s1 == KIND_SAMPLE);

	always_comb begin
		set_bit   = 1'b0;
		clr_bit   = 1'b0;
		bits_next = bits_q;
		if (is_sample && in_range) begin
			set_bit = sample_s1 > thr_high_q[channel_s1];
			clr_bit = sample_s1 < thr_low_q[channel_s1];
			// clear wins over set
			if (clr_bit) begin
				bits_next[channel_s1] = 1'b0;
			end else if (set_bit) begin
				bits_next[channel_s1] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_load && in_range) begin
			thr_high_q[channel_s1] <= high_s1;
			thr_low_q[channel_s1]  <= low_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q        <= '0;
			snap_valid_s2 <= 1'b0;
		end else if (advance) begin
			bits_q        <= bits_next;
			snap_valid_s2 <= is_sample && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			snap_pattern_s2 <= bits_next;
		end
	end

	assign snap = '{valid: snap_valid_s2, pattern: snap_pattern_s2};

endmodule

[hdl/lste_track.sv]
module lste_track (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  lste_pkg::cfg_idx_t   cfg_index,
	input  lste_pkg::cfg_data_t  cfg_data,
	input  lste_pkg::snap_t      snap,
	output logic                 advance,
	lste_out_if.source           results
);
	import lste_pkg::*;

	cfg_data_t normal_lim_q;
	cfg_data_t edge_lim_q;

	cnt_t  kept_count_q;
	chan_t kept_left_q;
	chan_t kept_right_q;
	chan_t scan_left_q;
	chan_t scan_right_q;
	err_t  prior_error_q;

	cnt_t  cnt;
	chan_t left;
	chan_t right;
	cnt_t  span;
	logic  gap;
	cnt_t  cnt_f;
	chan_t left_f;
	chan_t right_f;
	logic  edge_f;
	logic  fresh;
	chan_t sl;
	chan_t sr;
	err_t  dl;
	err_t  dr;
	logic signed [ERR_BITS:0] sum;
	logic signed [ERR_BITS:0] sum_adj;
	err_t  err;

	logic  out_valid_q;

	assign advance = !out_valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_lim_q <= NORMAL_WIDTH_RST;
			edge_lim_q   <= EDGE_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NORMAL_WIDTH: normal_lim_q <= cfg_data;
				REG_EDGE_COUNT:   edge_lim_q   <= cfg_data;
			endcase
		end
	end

	always_comb begin
		cnt   = '0;
		left  = '0;
		right = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			cnt = cnt + cnt_t'(snap.pattern[i]);
		end
		for (int i = CHANNELS - 1; i >= 0; i--) begin
			if (snap.pattern[i]) begin
				left = chan_t'(i);
			end
		end
		for (int i = 0; i < CHANNELS; i++) begin
			if (snap.pattern[i]) begin
				right = chan_t'(i);
			end
		end
	end

	assign span = cnt_t'(right - left) + cnt_t'(1);
	assign gap  = (cnt >= TRACK_MIN) && (span != cnt);

	assign cnt_f   = gap ? kept_count_q : cnt;
	assign left_f  = gap ? kept_left_q  : left;
	assign right_f = gap ? kept_right_q : right;

	assign edge_f = (left_f == CHAN_ZERO) || (right_f == CHAN_ZERO) ||
		(left_f == EDGE_TOP) || (right_f == EDGE_TOP) || (cnt_f > edge_lim_q);

	assign fresh = cnt_f < normal_lim_q;
	assign sl    = fresh ? left_f  : scan_left_q;
	assign sr    = fresh ? right_f : scan_right_q;

	assign dl = dir_entry(sl);
	assign dr = dir_entry(sr);

	// halve the sum, truncating toward zero
	assign sum     = {dl[ERR_BITS-1], dl} + {dr[ERR_BITS-1], dr};
	assign sum_adj = sum + {{ERR_BITS{1'b0}}, sum[ERR_BITS]};

	always_comb begin
		if (cnt_f < TRACK_MIN) begin
			if (prior_error_q > err_t'(0)) begin
				err = err_t'(1);
			end else if (prior_error_q < err_t'(0)) begin
				err = -err_t'(1);
			end else begin
				err = err_t'(0);
			end
		end else begin
			err = sum_adj[ERR_BITS:1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_count_q  <= '0;
			kept_left_q   <= '0;
			kept_right_q  <= '0;
			scan_left_q   <= '0;
			scan_right_q  <= '0;
			prior_error_q <= '0;
		end else if (advance && snap.valid) begin
			if (!gap) begin
				kept_count_q <= cnt;
				kept_left_q  <= left;
				kept_right_q <= right;
			end
			if (cnt_f >= TRACK_MIN && fresh) begin
				scan_left_q  <= left_f;
				scan_right_q <= right_f;
			end
			prior_error_q <= err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= snap.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && snap.valid) begin
			results.pattern     <= snap.pattern;
			results.track_count <= cnt_f;
			results.left_point  <= left_f;
			results.right_point <= right_f;
			results.held        <= gap;
			results.edge_res    <= edge_f;
			results.steer_error <= err;
		end
	end

	assign results.valid = out_valid_q;

endmodule

[bench/line_sensor_track_error_test.sv]
module line_sensor_track_error_test;
	timeunit 1ns;
	timeprecision 1ps;

	import lste_pkg::*;

	localparam int SMP_BITS    = 12;
	localparam int SMP_MAX     = (1 << SMP_BITS) - 1;
	localparam int PHASES      = 7;
	localparam int PHASE_WORDS = 100;
	localparam int HOLD_CYCLES = 200;
	localparam int QUIET_LIMIT = 1000;
	localparam int DRAIN_GAP   = 8;

	typedef logic [SMP_BITS-1:0] level_t;

	typedef struct packed {
		kind_t  kind;
		chan_t  channel;
		level_t sample;
		level_t high_threshold;
		level_t low_threshold;
		logic   last;
	} scan_word_t;

	typedef struct packed {
		pattern_t pattern;
		cnt_t     track_count;
		chan_t    left_point;
		chan_t    right_point;
		logic     held;
		logic     edge_res;
		err_t     steer_error;
	} track_result_t;

	typedef struct packed {
		scan_word_t    word;
		logic          typed;
		track_result_t res;
	} stim_row_t;

	localparam track_result_t NO_RES   = '0;
	localparam track_result_t NO_TRACK = '{15'h0, 4'd0, 4'd0, 4'd0, 1'b0, 1'b1, 6'sd0};

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cfg_we = 1'b0;
	cfg_idx_t  cfg_index = REG_NORMAL_WIDTH;
	cfg_data_t cfg_data = '0;

	lste_in_if #(.SAMPLE_BITS(SMP_BITS)) items_if ();
	lste_out_if results_if ();

	line_sensor_track_error #(.SAMPLE_BITS(SMP_BITS)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.items     (items_if),
		.results   (results_if)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// sensor and track state
	level_t    thr_hi [CHANNELS];
	level_t    thr_lo [CHANNELS];
	pattern_t  lit_bits;
	int        kept_cnt, kept_l, kept_r;
	int        scan_l, scan_r;
	int        prior_err;
	cfg_data_t width_lim, edge_lim;
	int        steer_table [15] = '{-30, -20, -16, -12, -10, -7, -3, 0, 3, 7, 10, 12, 16, 20, 30};

	track_result_t track_q [$];
	int words_sent = 0;
	int results_seen = 0;
	int holds_seen = 0;
	int mismatches = 0;
	int quiet = 0;
	int rx_stall = 0;
	bit rx_calm = 1'b0;
	bit long_hold_done = 1'b0;

	function automatic bit sensor_update(input scan_word_t w, output track_result_t r);
		int n, l, rt, err;
		bit gap, at_edge;
		n = 0;
		l = 0;
		rt = 0;
		r = '0;
		if (w.kind == KIND_LOAD) begin
			if (w.channel < CHANNELS) begin
				thr_hi[w.channel] = w.high_threshold;
				thr_lo[w.channel] = w.low_threshold;
			end
			return 1'b0;
		end
		if (w.channel < CHANNELS) begin
			if (w.sample > thr_hi[w.channel]) lit_bits[w.channel] = 1'b1;
			if (w.sample < thr_lo[w.channel]) lit_bits[w.channel] = 1'b0;
		end
		if (!w.last) return 1'b0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (lit_bits[i]) begin
				if (n == 0) l = i;
				rt = i;
				n++;
			end
		end
		gap = (n >= 2) && (rt - l + 1 != n);
		if (gap) begin
			holds_seen++;
			n = kept_cnt;
			l = kept_l;
			rt = kept_r;
		end else begin
			if (n > 15) n = 15;
			kept_cnt = n;
			kept_l = l;
			kept_r = rt;
		end
		at_edge = (l == 0) || (rt == 0) || (l == CHANNELS - 1) || (rt == CHANNELS - 1) ||
			(n > int'(edge_lim));
		if (n < 2) begin
			err = (prior_err > 0) ? 1 : ((prior_err < 0) ? -1 : 0);
		end else begin
			if (n < int'(width_lim)) begin
				scan_l = l;
				scan_r = rt;
			end
			err = (steer_table[scan_l > 14 ? 14 : scan_l] +
				steer_table[scan_r > 14 ? 14 : scan_r]) / 2;
		end
		prior_err = err;
		r.pattern = lit_bits;
		r.track_count = cnt_t'(n);
		r.left_point = chan_t'(l);
		r.right_point = chan_t'(rt);
		r.held = gap;
		r.edge_res = at_edge;
		r.steer_error = err_t'(err);
		return 1'b1;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// a level that sets or clears the channel under its current thresholds, or a random level where none can
	function automatic level_t level_for(input int c, input bit want);
		int floor_v;
		if (want) begin
			floor_v = int'(thr_hi[c]) + 1;
			if (floor_v < int'(thr_lo[c])) floor_v = int'(thr_lo[c]);
			if (floor_v <= SMP_MAX) return level_t'($urandom_range(floor_v, SMP_MAX));
		end else if (thr_lo[c] > 0) begin
			return level_t'($urandom_range(0, int'(thr_lo[c]) - 1));
		end
		return level_t'($urandom_range(0, SMP_MAX));
	endfunction

	task automatic send_word(input scan_word_t w, input bit typed, input track_result_t typed_res,
		input bit calm);
		int gap;
		bit has;
		track_result_t res;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			items_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items_if.valid <= 1'b1;
		items_if.kind <= w.kind;
		items_if.channel <= w.channel;
		items_if.sample <= w.sample;
		items_if.high_threshold <= w.high_threshold;
		items_if.low_threshold <= w.low_threshold;
		items_if.last <= w.last;
		@(posedge clk);
		while (!items_if.ready) @(posedge clk);
		words_sent++;
		has = sensor_update(w, res);
		if (has) track_q.push_back(typed ? typed_res : res);
	endtask

	task automatic load_word(input int c, input bit good, input bit calm);
		scan_word_t w;
		w.kind = KIND_LOAD;
		w.channel = chan_t'(c);
		w.sample = level_t'($urandom_range(0, SMP_MAX));
		if (good) begin
			w.low_threshold = level_t'($urandom_range(1, 2000));
			w.high_threshold = level_t'($urandom_range(int'(w.low_threshold), 4000));
		end else begin
			w.low_threshold = level_t'($urandom_range(0, SMP_MAX));
			w.high_threshold = level_t'($urandom_range(0, SMP_MAX));
		end
		w.last = 1'($urandom_range(0, 1));
		send_word(w, 1'b0, NO_RES, calm);
	endtask

	task automatic noise_word(input bit last, input bit calm);
		scan_word_t w;
		w.kind = KIND_SAMPLE;
		w.channel = chan_t'($urandom_range(0, 15));
		w.sample = level_t'($urandom_range(0, SMP_MAX));
		w.high_threshold = level_t'($urandom_range(0, SMP_MAX));
		w.low_threshold = level_t'($urandom_range(0, SMP_MAX));
		w.last = last;
		send_word(w, 1'b0, NO_RES, calm);
	endtask

	task automatic aim_word(input int c, input bit want, input bit last, input bit calm);
		scan_word_t w;
		w.kind = KIND_SAMPLE;
		w.channel = chan_t'(c);
		w.sample = level_for(c, want);
		w.high_threshold = level_t'($urandom_range(0, SMP_MAX));
		w.low_threshold = level_t'($urandom_range(0, SMP_MAX));
		w.last = last;
		send_word(w, 1'b0, NO_RES, calm);
	endtask

	// one scan: steer the channel bits toward a chosen pattern, then close with last
	task automatic run_scan(input bit calm);
		pattern_t goal;
		int r, wd, l, start, c;
		r = $urandom_range(0, 99);
		wd = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : $urandom_range(1, 6);
		l = $urandom_range(0, CHANNELS - wd);
		goal = pattern_t'(((1 << wd) - 1) << l);
		if (r >= 55 && r < 70) goal[$urandom_range(0, CHANNELS - 1)] ^= 1'b1;
		else if (r >= 70 && r < 78) goal = '0;
		else if (r >= 78 && r < 85) goal = '1;
		else if (r >= 85) goal = pattern_t'($urandom_range(0, 32767));
		if ($urandom_range(0, 99) < 10)
			load_word($urandom_range(0, 15), $urandom_range(0, 99) < 80, calm);
		start = $urandom_range(0, CHANNELS - 1);
		for (int k = 0; k < CHANNELS; k++) begin
			c = (start + k) % CHANNELS;
			if ($urandom_range(0, 99) < 6) noise_word(1'b0, calm);
			if (lit_bits[c] != goal[c] || $urandom_range(0, 99) < 10)
				aim_word(c, goal[c], 1'b0, calm);
		end
		if ($urandom_range(0, 99) < 5) begin
			noise_word(1'b1, calm);
		end else begin
			c = $urandom_range(0, CHANNELS - 1);
			aim_word(c, goal[c], 1'b1, calm);
		end
	endtask

	task automatic write_limits(input cfg_data_t nw, input cfg_data_t ec);
		cfg_we <= 1'b1;
		cfg_index <= REG_NORMAL_WIDTH;
		cfg_data <= nw;
		@(posedge clk);
		cfg_index <= REG_EDGE_COUNT;
		cfg_data <= ec;
		@(posedge clk);
		cfg_we <= 1'b0;
		width_lim = nw;
		edge_lim = ec;
	endtask

	task automatic drain();
		items_if.valid <= 1'b0;
		while (track_q.size() != 0) @(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	// receiver side: random stalls, one long hold-off once results are flowing
	always @(posedge clk) begin
		if (!arst_n) begin
			results_if.ready <= 1'b0;
		end else if (!long_hold_done && results_seen >= 25) begin
			long_hold_done = 1'b1;
			rx_stall = HOLD_CYCLES - 1;
			results_if.ready <= 1'b0;
		end else if (rx_stall > 0) begin
			rx_stall--;
			results_if.ready <= 1'b0;
		end else if (!rx_calm && $urandom_range(0, 99) < 25) begin
			rx_stall = pick_gap();
			if (rx_stall > 0) rx_stall--;
			else rx_stall = 0;
			results_if.ready <= 1'b0;
		end else begin
			results_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		track_result_t want;
		if (arst_n) begin
			if (results_if.valid && results_if.ready) begin
				results_seen++;
				if (track_q.size() == 0) begin
					$error("result word with nothing expected: pattern %h", results_if.pattern);
					mismatches++;
				end else begin
					want = track_q.pop_front();
					if (results_if.pattern !== want.pattern) begin
						$error("pattern: expected %h got %h", want.pattern, results_if.pattern);
						mismatches++;
					end
					if (results_if.track_count !== want.track_count) begin
						$error("track_count: expected %0d got %0d", want.track_count,
							results_if.track_count);
						mismatches++;
					end
					if (results_if.left_point !== want.left_point) begin
						$error("left_point: expected %0d got %0d", want.left_point,
							results_if.left_point);
						mismatches++;
					end
					if (results_if.right_point !== want.right_point) begin
						$error("right_point: expected %0d got %0d", want.right_point,
							results_if.right_point);
						mismatches++;
					end
					if (results_if.held !== want.held) begin
						$error("held: expected %b got %b", want.held, results_if.held);
						mismatches++;
					end
					if (results_if.edge_res !== want.edge_res) begin
						$error("edge_res: expected %b got %b", want.edge_res, results_if.edge_res);
						mismatches++;
					end
					if (results_if.steer_error !== want.steer_error) begin
						$error("steer_error: expected %0d got %0d", want.steer_error,
							results_if.steer_error);
						mismatches++;
					end
				end
			end
			if ((results_if.valid && results_if.ready) || (items_if.valid && items_if.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("no word moved for %0d cycles, %0d results outstanding", quiet,
					track_q.size());
				$display("line_sensor_track_error_test: done, errors");
				$finish;
			end
		end
	end

	stim_row_t directed_rows [20];

	initial begin
		int phase_end;
		cfg_data_t nw, ec;
		int nw_set [PHASES];
		int ec_set [PHASES];

		nw_set = '{7, 2, 15, 4, 0, 15, 2};
		ec_set = '{10, 0, 15, 6, 0, 0, 15};
		items_if.valid = 1'b0;
		items_if.kind = KIND_SAMPLE;
		items_if.channel = '0;
		items_if.sample = '0;
		items_if.high_threshold = '0;
		items_if.low_threshold = '0;
		items_if.last = 1'b0;
		lit_bits = '0;
		kept_cnt = 0;
		kept_l = 0;
		kept_r = 0;
		scan_l = 0;
		scan_r = 0;
		prior_err = 0;
		width_lim = NORMAL_WIDTH_RST;
		edge_lim = EDGE_COUNT_RST;
		for (int i = 0; i < CHANNELS; i++) begin
			thr_hi[i] = '0;
			thr_lo[i] = '0;
		end

		directed_rows = '{
			'{'{KIND_LOAD,   4'd0,  12'd0,    12'd4095, 12'd0,    1'b1}, 1'b0, NO_RES},
			'{'{KIND_LOAD,   4'd14, 12'd4095, 12'd0,    12'd4095, 1'b0}, 1'b0, NO_RES},
			'{'{KIND_LOAD,   4'd1,  12'd0,    12'd100,  12'd50,   1'b0}, 1'b0, NO_RES},
			'{'{KIND_LOAD,   4'd2,  12'd0,    12'd100,  12'd50,   1'b0}, 1'b0, NO_RES},
			'{'{KIND_LOAD,   4'd7,  12'd0,    12'd2047, 12'd1024, 1'b0}, 1'b0, NO_RES},
			'{'{KIND_SAMPLE, 4'd15, 12'd4095, 12'd4095, 12'd4095, 1'b1}, 1'b1, NO_TRACK},
			'{'{KIND_LOAD,   4'd15, 12'd0,    12'd5,    12'd5,    1'b0}, 1'b0, NO_RES},
			'{'{KIND_SAMPLE, 4'd0,  12'd4095, 12'd0,    12'd0,    1'b0}, 1'b0, NO_RES},
			'{'{KIND_SAMPLE, 4'd14, 12'd2000, 12'd0,    12'd0,    1'b1}, 1'b1, NO_TRACK},
			'{'{KIND_SAMPLE, 4'd1,  12'd101,  12'd0,    12'd0,    1'b0}, 1'b0, NO_RES},
			'{'{KIND_SAMPLE, 4'd2,  12'd4095, 12'd0,    12'd0,    1'b1}, 1'b0, NO_RES},
			'{'{KIND_SAMPLE, 4'd7,  12'd4000, 12'd0,    12'd0,    1'b1}, 1'b0, NO_RES},
			'{'{KIND_SAMPLE, 4'd2,  12'd10,   12'd0,    12'd0,    1'b0}, 1'b0, NO_RES},
			'{'{KIND_SAMPLE, 4'd1,  12'd0,    12'd0,    12'd0,    1'b1}, 1'b0, NO_RES},
			'{'{KIND_LOAD,   4'd13, 12'd0,    12'd0,    12'd0,    1'b0}, 1'b0, NO_RES},
			'{'{KIND_SAMPLE, 4'd13, 12'd0,    12'd0,    12'd0,    1'b0}, 1'b0, NO_RES},
			'{'{KIND_SAMPLE, 4'd13, 12'd1,    12'd0,    12'd0,    1'b1}, 1'b0, NO_RES},
			'{'{KIND_LOAD,   4'd14, 12'd0,    12'd0,    12'd0,    1'b0}, 1'b0, NO_RES},
			'{'{KIND_SAMPLE, 4'd14, 12'd4095, 12'd0,    12'd0,    1'b1}, 1'b0, NO_RES},
			'{'{KIND_SAMPLE, 4'd7,  12'd0,    12'd0,    12'd0,    1'b1}, 1'b0, NO_RES}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].res, 1'b0);

		phase_end = words_sent;
		for (int p = 0; p < PHASES; p++) begin
			drain();
			nw = (nw_set[p] == 0) ? cfg_data_t'($urandom_range(2, 15)) : cfg_data_t'(nw_set[p]);
			ec = (nw_set[p] == 0) ? cfg_data_t'($urandom_range(0, 15)) : cfg_data_t'(ec_set[p]);
			write_limits(nw, ec);
			rx_calm = (p == 2);
			if (p == 0) begin
				for (int c = 0; c < CHANNELS; c++) load_word(c, 1'b1, 1'b0);
			end
			phase_end += PHASE_WORDS;
			while (words_sent < phase_end) run_scan($urandom_range(0, 99) < 15);
		end

		drain();
		$display("%0d words driven over %0d limit settings, %0d track results checked",
			words_sent, PHASES, results_seen);
		$display("%0d scans kept the previous track; receiver held off %0d cycles once",
			holds_seen, HOLD_CYCLES);
		if (mismatches == 0)
			$display("line_sensor_track_error_test: done, clean");
		else
			$display("line_sensor_track_error_test: done, errors");
		$finish;
	end

endmodule
